// ===== hw/rtl/xor_delta_patch_decoder_defines.svh =====
// Assertion macros shared by the XOR-delta patch decoder RTL.
`ifndef XOR_DELTA_PATCH_DECODER_DEFINES_SVH
`define XOR_DELTA_PATCH_DECODER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define XDP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define XDP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define XDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/xdp_pkg.sv =====
// Package with the item types and constants of the XOR-delta patch decoder.
`default_nettype none
package xdp_pkg;

  // Frame size register and write index width.
  localparam int unsigned FRAME_W = 21;
  localparam int unsigned PIX_W   = 20;
  localparam int unsigned RUN_W   = 14;
  localparam int unsigned CNT_W   = 15;

  // Largest frame the block addresses.
  localparam logic [FRAME_W-1:0] MAX_FRAME_PIXELS = 21'd1048576;
  localparam logic [FRAME_W-1:0] FRAME_SIZE_RST   = 21'd1048576;

  // Result codes.
  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_RUN      = 2'd1,
    KIND_END      = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_t;

  // One byte of the command stream.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_start;
  } in_item_t;

  // One patch for the frame store.
  typedef struct packed {
    kind_t            patch_kind;
    logic [PIX_W-1:0] pixel_index;
    logic [RUN_W-1:0] run_length;
    logic [7:0]       xor_value;
  } out_item_t;

  // Decoded result handed from the parser to the output register.
  typedef struct packed {
    logic      vld;
    out_item_t item;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/xdp_core.sv =====
// Command parser: parser state, pixel index and the per-byte decode.
`default_nettype none
`include "xor_delta_patch_decoder_defines.svh"
module xdp_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire xdp_pkg::in_item_t          item,
  input  wire logic [xdp_pkg::FRAME_W-1:0] frame_size,
  output xdp_pkg::result_t                res
);
  import xdp_pkg::*;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_SRUN_COUNT,
    PH_SRUN_VALUE,
    PH_LITERAL,
    PH_WORD_LO,
    PH_WORD_HI,
    PH_LRUN_VALUE
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [RUN_W-1:0]   pend_r, pend_nxt;
  logic [7:0]         wlo_r, wlo_nxt;
  logic [FRAME_W-1:0] widx_r, widx_nxt;
  logic               stop_r, stop_nxt;
  logic [FRAME_W-1:0] limit;

  // True when count pixels starting at wi stay within the limit.
  function automatic logic fits_f(logic [FRAME_W-1:0] wi, logic [CNT_W-1:0] cnt,
                                  logic [FRAME_W-1:0] lim);
    return ({1'b0, wi} + {7'd0, cnt}) <= {1'b0, lim};
  endfunction

  // Index after a skip, saturated at the limit.
  function automatic logic [FRAME_W-1:0] skip_f(logic [FRAME_W-1:0] wi,
                                                logic [CNT_W-1:0] cnt,
                                                logic [FRAME_W-1:0] lim);
    logic [FRAME_W:0] sum;
    sum = {1'b0, wi} + {7'd0, cnt};
    if (sum > {1'b0, lim}) begin
      return (wi > lim) ? wi : lim;
    end
    return sum[FRAME_W-1:0];
  endfunction

  // Writes are checked against the smaller of the register and the frame cap.
  assign limit = (frame_size > MAX_FRAME_PIXELS) ? MAX_FRAME_PIXELS : frame_size;

  // Decode of one byte against the parser state.
  always_comb begin
    logic [15:0]      word;
    logic [RUN_W-1:0] cnt;
    logic [RUN_W-1:0] pend_dec;
    if (item.stream_start) begin
      phase_nxt = PH_CMD;
      pend_nxt  = '0;
      wlo_nxt   = '0;
      widx_nxt  = '0;
      stop_nxt  = 1'b0;
    end else begin
      phase_nxt = phase_r;
      pend_nxt  = pend_r;
      wlo_nxt   = wlo_r;
      widx_nxt  = widx_r;
      stop_nxt  = stop_r;
    end
    word     = {item.code_byte, wlo_nxt};
    cnt      = '0;
    pend_dec = pend_nxt - RUN_W'(1);
    res.vld  = 1'b0;
    res.item.patch_kind  = KIND_PIXEL;
    res.item.pixel_index = widx_nxt[PIX_W-1:0];
    res.item.run_length  = '0;
    res.item.xor_value   = '0;

    if (!stop_nxt) begin
      case (phase_nxt)
        PH_CMD: begin
          if (!item.code_byte[7]) begin
            if (item.code_byte[6:0] == 7'd0) begin
              phase_nxt = PH_SRUN_COUNT;
            end else begin
              // Literal header: count checked up front.
              cnt = {7'd0, item.code_byte[6:0]};
              if (!fits_f(widx_nxt, {1'b0, cnt}, limit)) begin
                res.vld = 1'b1;
                res.item.patch_kind = KIND_OVERFLOW;
                res.item.run_length = cnt;
                stop_nxt  = 1'b1;
                phase_nxt = PH_CMD;
              end else begin
                pend_nxt  = cnt;
                phase_nxt = PH_LITERAL;
              end
            end
          end else if (item.code_byte[6:0] == 7'd0) begin
            phase_nxt = PH_WORD_LO;
          end else begin
            widx_nxt = skip_f(widx_nxt, {8'd0, item.code_byte[6:0]}, limit);
          end
        end
        PH_SRUN_COUNT: begin
          pend_nxt  = {6'd0, item.code_byte};
          phase_nxt = PH_SRUN_VALUE;
        end
        PH_SRUN_VALUE, PH_LRUN_VALUE: begin
          // Run value byte: overflow, empty run or one run patch.
          phase_nxt = PH_CMD;
          if (!fits_f(widx_nxt, {1'b0, pend_nxt}, limit)) begin
            res.vld = 1'b1;
            res.item.patch_kind = KIND_OVERFLOW;
            res.item.run_length = pend_nxt;
            res.item.xor_value  = item.code_byte;
            stop_nxt = 1'b1;
          end else if (pend_nxt != '0) begin
            res.vld = 1'b1;
            res.item.patch_kind = KIND_RUN;
            res.item.run_length = pend_nxt;
            res.item.xor_value  = item.code_byte;
            widx_nxt = widx_nxt + {7'd0, pend_nxt};
          end
        end
        PH_LITERAL: begin
          res.vld = 1'b1;
          res.item.patch_kind = KIND_PIXEL;
          res.item.run_length = RUN_W'(1);
          res.item.xor_value  = item.code_byte;
          widx_nxt = widx_nxt + FRAME_W'(1);
          pend_nxt = pend_dec;
          if (pend_dec == '0) begin
            phase_nxt = PH_CMD;
          end
        end
        PH_WORD_LO: begin
          wlo_nxt   = item.code_byte;
          phase_nxt = PH_WORD_HI;
        end
        PH_WORD_HI: begin
          phase_nxt = PH_CMD;
          if (word == 16'd0) begin
            res.vld = 1'b1;
            res.item.patch_kind = KIND_END;
            stop_nxt = 1'b1;
          end else if (!word[15]) begin
            widx_nxt = skip_f(widx_nxt, word[14:0], limit);
          end else if (!word[14]) begin
            cnt = word[13:0];
            if (!fits_f(widx_nxt, {1'b0, cnt}, limit)) begin
              res.vld = 1'b1;
              res.item.patch_kind = KIND_OVERFLOW;
              res.item.run_length = cnt;
              stop_nxt = 1'b1;
            end else if (cnt != '0) begin
              pend_nxt  = cnt;
              phase_nxt = PH_LITERAL;
            end
          end else begin
            pend_nxt  = word[13:0];
            phase_nxt = PH_LRUN_VALUE;
          end
        end
        default: begin
          phase_nxt = PH_CMD;
        end
      endcase
    end
  end

  // Parser state advances only when a byte is decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      pend_r  <= '0;
      wlo_r   <= '0;
      widx_r  <= '0;
      stop_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      wlo_r   <= wlo_nxt;
      widx_r  <= widx_nxt;
      stop_r  <= stop_nxt;
    end
  end

  `XDP_ASSERT_SAME(a_stop_idle, stop_r, phase_r == PH_CMD, "stopped parser not idle")
  `XDP_ASSERT_ALWAYS(a_widx_cap, widx_r <= MAX_FRAME_PIXELS, "write index beyond frame cap")
  `XDP_ASSERT_SAME(a_lit_pend, phase_r == PH_LITERAL, pend_r != '0,
                   "literal phase with no bytes pending")
  `XDP_ASSERT_NEXT(a_end_stops, step && res.vld && res.item.patch_kind == KIND_END,
                   stop_r, "end code did not stop the parser")

endmodule
`default_nettype wire

// ===== hw/rtl/xor_delta_patch_decoder.sv =====
// An accepted item is held in the input register, decoded, and its result held in the result register.
// Throughput: one item per cycle while the output does not stall; the combinational byte decode sets that rate.
// Output stall holds the result register and, once the input register is full, the input.
// Reset (rst_n, synchronous): parser idle, index zero, frame size 1048576, no item held.
// Items that cause no result still pass through the input register and update state.
`default_nettype none
`include "xor_delta_patch_decoder_defines.svh"
module xor_delta_patch_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire xdp_pkg::in_item_t           in_item,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output xdp_pkg::out_item_t               out_item,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [xdp_pkg::FRAME_W-1:0] cfg_data
);
  import xdp_pkg::*;

  logic               in_vld_r;
  in_item_t           in_item_r;
  logic               out_vld_r;
  out_item_t          out_item_r;
  logic [FRAME_W-1:0] frame_size_r;
  logic               step;
  result_t            res;

  // A held item is decoded when the result register is free or being emptied.
  assign step     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !step;
  assign cfg_ready = 1'b1;

  // Frame size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_size_r <= FRAME_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      frame_size_r <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_item_r <= in_item;
    end
  end

  xdp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .item       (in_item_r),
    .frame_size (frame_size_r),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= res.vld;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.vld) begin
      out_item_r <= res.item;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  `XDP_ASSERT_SAME(a_pixel_len, out_vld_r && out_item_r.patch_kind == KIND_PIXEL,
                   out_item_r.run_length == RUN_W'(1), "pixel patch length is not one")
  `XDP_ASSERT_SAME(a_end_zero, out_vld_r && out_item_r.patch_kind == KIND_END,
                   out_item_r.run_length == '0 && out_item_r.xor_value == '0,
                   "end result carries data")
  `XDP_ASSERT_SAME(a_stall_full, in_stall, in_vld_r && out_vld_r && out_stall,
                   "input stalled without a blocked item")

endmodule
`default_nettype wire

// ===== tb/tb_xor_delta_patch_decoder.sv =====
// Self-checking testbench for the XOR-delta patch decoder with a built-in patch predictor.
`timescale 1ns / 1ps
module tb_xor_delta_patch_decoder;
  import xdp_pkg::*;

  // Parser states of the predictor.
  typedef enum logic [2:0] {
    ST_COMMAND,
    ST_RUN_COUNT,
    ST_RUN_VALUE,
    ST_LITERAL,
    ST_WORD_LO,
    ST_WORD_HI,
    ST_LONG_RUN_VALUE
  } parse_state_e;

  // Command stream codes.
  localparam logic [7:0]  CMD_RUN            = 8'h00;
  localparam logic [7:0]  CMD_LONG           = 8'h80;
  localparam logic [7:0]  SKIP_FLAG          = 8'h80;
  localparam logic [15:0] END_WORD           = 16'h0000;
  localparam logic [15:0] LONG_LITERAL_FLAG  = 16'h8000;
  localparam logic [15:0] LONG_RUN_FLAG      = 16'hC000;
  localparam logic [15:0] LONG_SKIP_MAX      = 16'h7FFF;
  localparam int unsigned LONG_COUNT_MAX     = 16383;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [FRAME_W-1:0]  cfg_data  = '0;

  xor_delta_patch_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predictor state, a copy of what the block keeps.
  logic [FRAME_W-1:0] frame_size_copy = FRAME_SIZE_RST;
  parse_state_e       parse_state     = ST_COMMAND;
  int unsigned        pending_count   = 0;
  logic [7:0]         word_low        = 8'h00;
  int unsigned        write_index     = 0;
  bit                 stream_stopped  = 1'b0;

  // Patches still to come from the block, oldest first.
  out_item_t   expected_patches[$];
  int          mismatch_count = 0;
  int          items_sent     = 0;
  bit          start_pending  = 1'b0;
  bit          sender_idle    = 1'b1;
  bit          receiver_idle  = 1'b1;
  int          hold_cycles    = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Run limit far beyond the slowest correct run.
  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Writes go no further than the frame, and never past the largest frame.
  function automatic int unsigned write_limit();
    int unsigned lim;
    lim = 32'(frame_size_copy);
    if (lim > 32'(MAX_FRAME_PIXELS)) lim = 32'(MAX_FRAME_PIXELS);
    return lim;
  endfunction

  function automatic out_item_t make_patch(kind_t kind, int unsigned at, int unsigned len,
                                           logic [7:0] val);
    out_item_t p;
    p.patch_kind  = kind;
    p.pixel_index = at[PIX_W-1:0];
    p.run_length  = len[RUN_W-1:0];
    p.xor_value   = val;
    return p;
  endfunction

  // A skip saturates at the limit but never moves the index back.
  function automatic void advance_index(int unsigned count);
    int unsigned lim;
    int unsigned target;
    lim = write_limit();
    target = write_index + count;
    if (target > lim) target = (write_index > lim) ? write_index : lim;
    write_index = target;
  endfunction

  function automatic out_item_t flag_overflow(int unsigned count, logic [7:0] val);
    stream_stopped = 1'b1;
    parse_state = ST_COMMAND;
    return make_patch(KIND_OVERFLOW, write_index, count, val);
  endfunction

  // Literal header: overflow now if the whole count does not fit.
  function automatic bit open_literal(int unsigned count, output out_item_t p);
    p = '0;
    if (write_index + count > write_limit()) begin
      p = flag_overflow(count, 8'h00);
      return 1'b1;
    end
    pending_count = count;
    parse_state = (count == 0) ? ST_COMMAND : ST_LITERAL;
    return 1'b0;
  endfunction

  // Decodes one stream byte; returns 1 when it gives a patch.
  function automatic bit decode_byte(in_item_t it, output out_item_t p);
    logic [7:0]  b;
    logic [15:0] w;
    int unsigned count;
    int unsigned at;
    b = it.code_byte;
    p = '0;
    if (it.stream_start) begin
      parse_state    = ST_COMMAND;
      pending_count  = 0;
      word_low       = 8'h00;
      write_index    = 0;
      stream_stopped = 1'b0;
    end
    if (stream_stopped) return 1'b0;
    case (parse_state)
      ST_COMMAND: begin
        if (!b[7]) begin
          if (b[6:0] == 7'd0) begin
            parse_state = ST_RUN_COUNT;
            return 1'b0;
          end
          return open_literal(32'(b[6:0]), p);
        end
        if (b[6:0] == 7'd0) begin
          parse_state = ST_WORD_LO;
          return 1'b0;
        end
        advance_index(32'(b[6:0]));
        return 1'b0;
      end
      ST_RUN_COUNT: begin
        pending_count = 32'(b);
        parse_state = ST_RUN_VALUE;
        return 1'b0;
      end
      ST_RUN_VALUE, ST_LONG_RUN_VALUE: begin
        count = pending_count;
        parse_state = ST_COMMAND;
        if (write_index + count > write_limit()) begin
          p = flag_overflow(count, b);
          return 1'b1;
        end
        if (count == 0) return 1'b0;
        p = make_patch(KIND_RUN, write_index, count, b);
        write_index += count;
        return 1'b1;
      end
      ST_LITERAL: begin
        at = write_index;
        write_index += 1;
        pending_count = (pending_count - 1) & 32'h7FFF;
        if (pending_count == 0) parse_state = ST_COMMAND;
        p = make_patch(KIND_PIXEL, at, 1, b);
        return 1'b1;
      end
      ST_WORD_LO: begin
        word_low = b;
        parse_state = ST_WORD_HI;
        return 1'b0;
      end
      ST_WORD_HI: begin
        w = {b, word_low};
        parse_state = ST_COMMAND;
        if (w == END_WORD) begin
          stream_stopped = 1'b1;
          p = make_patch(KIND_END, write_index, 0, 8'h00);
          return 1'b1;
        end
        if (!w[15]) begin
          advance_index(32'(w[14:0]));
          return 1'b0;
        end
        if (!w[14]) return open_literal(32'(w[13:0]), p);
        pending_count = 32'(w[13:0]);
        parse_state = ST_LONG_RUN_VALUE;
        return 1'b0;
      end
      default: begin
        parse_state = ST_COMMAND;
        return 1'b0;
      end
    endcase
  endfunction

  // Sends one item, with an optional idle burst before it, and predicts its patch.
  task automatic send_byte(input logic [7:0] b, input bit start);
    out_item_t p;
    if (sender_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= in_item_t'{code_byte: b, stream_start: start};
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (decode_byte(in_item_t'{code_byte: b, stream_start: start}, p))
      expected_patches.push_back(p);
  endtask

  // Sends one byte, marking it as a stream start if one is pending.
  task automatic stream_byte(input logic [7:0] b);
    send_byte(b, start_pending);
    start_pending = 1'b0;
  endtask

  task automatic stream_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) stream_byte(seq[i]);
  endtask

  // Escape byte followed by a little-endian command word.
  task automatic long_command(input logic [15:0] w);
    stream_byte(CMD_LONG);
    stream_byte(w[7:0]);
    stream_byte(w[15:8]);
  endtask

  // Writes the frame size once the block has drained and the output has settled.
  task automatic set_frame_size(input logic [FRAME_W-1:0] size);
    int quiet;
    in_valid <= 1'b0;
    while (expected_patches.size() != 0) @(posedge clk);
    quiet = 0;
    while (quiet < 4) begin
      @(posedge clk);
      quiet = out_stall ? 0 : quiet + 1;
    end
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    frame_size_copy = size;
  endtask

  // Receiver: long hold-offs on request, random stall bursts otherwise.
  initial begin : receiver_stall
    int burst;
    burst = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 13) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Compares every accepted patch with the oldest prediction.
  always @(posedge clk) begin : check_patches
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_patches.size() == 0) begin
        $error("unexpected patch kind %0d at pixel %0d", out_item.patch_kind,
               out_item.pixel_index);
        mismatch_count++;
      end else begin
        want = expected_patches.pop_front();
        if (out_item.patch_kind !== want.patch_kind) begin
          $error("patch_kind expected %0d got %0d", want.patch_kind, out_item.patch_kind);
          mismatch_count++;
        end
        if (out_item.pixel_index !== want.pixel_index) begin
          $error("pixel_index expected %0d got %0d", want.pixel_index, out_item.pixel_index);
          mismatch_count++;
        end
        if (out_item.run_length !== want.run_length) begin
          $error("run_length expected %0d got %0d", want.run_length, out_item.run_length);
          mismatch_count++;
        end
        if (out_item.xor_value !== want.xor_value) begin
          $error("xor_value expected %0h got %0h", want.xor_value, out_item.xor_value);
          mismatch_count++;
        end
      end
    end
  end

  // Every command form once, ending with an end code and an ignored byte.
  task automatic test_basic_commands();
    start_pending = 1'b1;
    stream_bytes('{8'd2, 8'h00, 8'hFF});
    stream_bytes('{CMD_RUN, 8'd3, 8'hAB});
    stream_bytes('{CMD_RUN, 8'd0, 8'h11});
    stream_byte(SKIP_FLAG | 8'd127);
    long_command(LONG_SKIP_MAX);
    long_command(LONG_LITERAL_FLAG);
    long_command(LONG_LITERAL_FLAG | 16'd1);
    stream_byte(8'h77);
    long_command(LONG_RUN_FLAG | 16'(LONG_COUNT_MAX));
    stream_byte(8'hEE);
    long_command(END_WORD);
    stream_byte(8'd5);
  endtask

  // Tiny frame: overflow at each point where it can occur, and skip saturation.
  task automatic test_overflow_and_saturation();
    set_frame_size(21'd4);
    start_pending = 1'b1;
    stream_byte(8'd127);
    start_pending = 1'b1;
    stream_bytes('{SKIP_FLAG | 8'd4, SKIP_FLAG | 8'd4, CMD_RUN, 8'd0, 8'h01});
    start_pending = 1'b1;
    stream_bytes('{CMD_RUN, 8'd5, 8'h99});
    start_pending = 1'b1;
    long_command(LONG_LITERAL_FLAG | 16'd16);
  endtask

  // Zero limit overflows every nonempty write; an oversized register is clamped.
  task automatic test_zero_and_clamped_limit();
    set_frame_size(21'd0);
    start_pending = 1'b1;
    stream_byte(8'd1);
    start_pending = 1'b1;
    long_command(LONG_RUN_FLAG);
    stream_byte(8'h42);
    set_frame_size({FRAME_W{1'b1}});
    start_pending = 1'b1;
    stream_bytes('{CMD_RUN, 8'hFF, 8'h01});
  endtask

  // Shrinking the frame under the current index: skips hold, empty runs overflow.
  task automatic test_index_past_limit();
    set_frame_size(MAX_FRAME_PIXELS);
    start_pending = 1'b1;
    stream_bytes('{SKIP_FLAG | 8'd127, 8'd3, 8'h01, 8'h02, 8'h03});
    set_frame_size(21'd100);
    stream_bytes('{SKIP_FLAG | 8'd5, CMD_RUN, 8'd0, 8'h33});
  endtask

  // The receiver holds off while literals keep coming, so the input backs up.
  task automatic test_output_backpressure();
    set_frame_size(MAX_FRAME_PIXELS);
    sender_idle = 1'b0;
    hold_cycles = 150;
    start_pending = 1'b1;
    stream_byte(8'd64);
    repeat (64) stream_byte(8'($urandom));
    long_command(END_WORD);
    sender_idle = 1'b1;
  endtask

  // One random command, mostly well formed, sometimes noise or a restart.
  task automatic random_command();
    int unsigned n;
    case ($urandom_range(0, 7))
      0, 1: begin
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
        stream_byte(n[7:0]);
        repeat ((n > write_limit()) ? 2 : n) stream_byte(8'($urandom));
      end
      2: stream_bytes('{CMD_RUN, 8'($urandom), 8'($urandom)});
      3: stream_byte(SKIP_FLAG | 8'($urandom_range(1, 127)));
      4: long_command(16'($urandom_range(1, 32'(LONG_SKIP_MAX))));
      5: begin
        n = (write_limit() < 64) ? $urandom_range(0, LONG_COUNT_MAX) : $urandom_range(0, 6);
        long_command(LONG_LITERAL_FLAG | 16'(n));
        repeat ((n > write_limit()) ? 2 : n) stream_byte(8'($urandom));
      end
      6: begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                        : $urandom_range(0, LONG_COUNT_MAX);
        long_command(LONG_RUN_FLAG | 16'(n));
        stream_byte(8'($urandom));
      end
      default: begin
        if ($urandom_range(0, 3) == 0) start_pending = 1'b1;
        stream_byte(8'($urandom));
      end
    endcase
  endtask

  task automatic random_stream();
    start_pending = 1'b1;
    repeat ($urandom_range(1, 10)) random_command();
    if ($urandom_range(0, 7) != 0) long_command(END_WORD);
  endtask

  task automatic random_streams(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) random_stream();
  endtask

  // Random streams under a range of frame sizes, with idling on both sides.
  task automatic test_random_streams();
    logic [FRAME_W-1:0] sizes[6];
    sizes = '{21'd37, 21'd1, 21'd600, {FRAME_W{1'b1}}, 21'd20000, MAX_FRAME_PIXELS};
    foreach (sizes[i]) begin
      set_frame_size(sizes[i]);
      random_streams(140);
    end
  endtask

  // Closing stretch at full rate with no idling anywhere.
  task automatic test_random_full_rate();
    set_frame_size(21'd300);
    sender_idle = 1'b0;
    receiver_idle = 1'b0;
    random_streams(200);
  endtask

  initial begin
    int guard;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_commands();
    test_overflow_and_saturation();
    test_zero_and_clamped_limit();
    test_index_past_limit();
    test_output_backpressure();
    test_random_streams();
    test_random_full_rate();
    in_valid <= 1'b0;
    guard = 0;
    while (expected_patches.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_patches.size() != 0) begin
      $error("%0d expected patches never arrived", expected_patches.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/xdp_pkg.sv
hw/rtl/xdp_core.sv
hw/rtl/xor_delta_patch_decoder.sv
tb/tb_xor_delta_patch_decoder.sv
